// ===== design/gtsc_pkg.sv =====
// ----------------------------------------------------------------------------
// gtsc_pkg: shared types and constants
// Op codes, search status codes, register indexes, sequencer states and field
// widths for the gain tap search calibrator.
// ----------------------------------------------------------------------------
package gtsc_pkg;

    localparam int SAMPLE_W  = 24;   // ADC reading / average
    localparam int SUM_W     = 40;   // sample accumulator
    localparam int COUNT_W   = 16;   // samples per average
    localparam int TIME_W    = 32;   // elapsed milliseconds
    localparam int TAP_W     = 8;    // digipot tap
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_DONE   = 2'd2,
        MODE_FAIL   = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_MIN  = 3'd0,
        REG_TARGET_MAX  = 3'd1,
        REG_SAMPLES     = 3'd2,
        REG_TIMEOUT     = 3'd3,
        REG_FIRST_TAP   = 3'd4,
        REG_TAP_INCR    = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_DIV  = 1'b1
    } seq_state_t;

endpackage

// ===== design/gtsc_if.sv =====
// ----------------------------------------------------------------------------
// gtsc_if: command and result channels
// Valid/ready channels carrying one command or one result per transaction.
// ----------------------------------------------------------------------------
interface gtsc_cmd_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             op;
    logic signed [gtsc_pkg::SAMPLE_W-1:0]   adc_value;
    logic                                   sample_ok;

    modport source (output valid, output op, output adc_value, output sample_ok,
                    input ready);
    modport sink   (input valid, input op, input adc_value, input sample_ok,
                    output ready);
endinterface

interface gtsc_res_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             search_status;
    logic [gtsc_pkg::TAP_W-1:0]             tap_now;
    logic                                   tap_write;
    logic signed [gtsc_pkg::SAMPLE_W-1:0]   average_value;
    logic                                   average_done;

    modport source (output valid, output search_status, output tap_now,
                    output tap_write, output average_value, output average_done,
                    input ready);
    modport sink   (input valid, input search_status, input tap_now,
                    input tap_write, input average_value, input average_done,
                    output ready);
endinterface

// ===== design/gtsc_div.sv =====
// ----------------------------------------------------------------------------
// gtsc_div: serial signed-by-unsigned divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module gtsc_div
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [gtsc_pkg::SUM_W-1:0]     dividend,
    input  logic [gtsc_pkg::COUNT_W-1:0]          divisor,
    output logic                                  done,
    output logic signed [gtsc_pkg::SAMPLE_W-1:0]  quotient
);

    localparam int STEPS = gtsc_pkg::SUM_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam int DW    = gtsc_pkg::SUM_W;
    localparam int VW    = gtsc_pkg::COUNT_W;
    localparam int QW    = gtsc_pkg::SAMPLE_W;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [DW-1:0]    dq_reg, dq_next;
    logic [VW-1:0]    rem_reg, rem_next;
    logic [VW-1:0]    dvs_reg, dvs_next;
    logic [VW:0]      rem_sh;
    logic [VW:0]      rem_sub;
    logic             ge;

    assign rem_sh  = {rem_reg, dq_reg[DW-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign ge      = rem_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[DW-1];
            dq_next   = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
            dq_next  = {dq_reg[DW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    // Quotient magnitude never exceeds 2^23, so the low bits carry it whole.
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(dq_reg[QW-1:0]) : $signed(dq_reg[QW-1:0]);

endmodule

// ===== design/gain_tap_search_calibrator_unit.sv =====
// ----------------------------------------------------------------------------
// gain_tap_search_calibrator_unit: digipot gain tap search
// Steps a digipot tap until the averaged ADC reading lands in a target window.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command per transaction: start search, ADC sample, or
//   one millisecond tick. res returns exactly one result per command: status,
//   current tap, a tap write request, the last average and an average flag.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle;
//   indexes beyond the register list are ignored.
// Latency and throughput:
//   Start, tick, plain samples and failed reads: result valid the cycle after
//   acceptance, one command per cycle while res keeps up.
//   The sample that completes an average runs the serial divider, one
//   quotient bit per cycle; its result is registered once the divider is
//   done, and cmd.ready stays low until then.
// Reset: search idle, tap 0, accumulator and timer cleared, registers at their
//   defaults; no clearing pass.
// Stall: one result register; while it is full and res.ready is low, cmd.ready
//   is low and nothing is lost.
// ----------------------------------------------------------------------------
module gain_tap_search_calibrator_unit
#(
    parameter int MAX_TAP = 255    // 1 .. 255
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [gtsc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gtsc_pkg::CFG_DATA_W-1:0]       cfg_data,
    gtsc_cmd_if.sink                              cmd,
    gtsc_res_if.source                            res
);

    localparam int SW = gtsc_pkg::SAMPLE_W;
    localparam int AW = gtsc_pkg::SUM_W;
    localparam int NW = gtsc_pkg::COUNT_W;
    localparam int TW = gtsc_pkg::TIME_W;
    localparam int PW = gtsc_pkg::TAP_W;

    localparam logic [PW-1:0] MAX_TAP_P = PW'(MAX_TAP);
    localparam logic [PW:0]   MAX_TAP_X = (PW+1)'(MAX_TAP);

    // configuration
    logic signed [SW-1:0] tmin_reg, tmax_reg;
    logic [NW-1:0]        spa_reg;
    logic [TW-1:0]        tlim_reg;
    logic [PW-1:0]        ftap_reg, tinc_reg;

    // search state
    gtsc_pkg::seq_state_t state_reg, state_next;
    gtsc_pkg::mode_t      mode_reg, mode_next;
    logic [PW-1:0]        tap_reg, tap_next;
    logic signed [AW-1:0] sum_reg, sum_next;
    logic [NW-1:0]        cnt_reg, cnt_next;
    logic [TW-1:0]        ms_reg, ms_next;
    logic signed [SW-1:0] avg_reg, avg_next;

    // result register
    logic                 rvalid_reg;
    gtsc_pkg::mode_t      rmode_reg;
    logic [PW-1:0]        rtap_reg;
    logic                 rwrite_reg;
    logic signed [SW-1:0] ravg_reg;
    logic                 rdone_reg;

    logic                 accept;
    logic                 load_res;
    logic                 wr, dn;
    logic                 judge_en;
    logic signed [SW-1:0] avg_j;
    logic signed [AW-1:0] sum_add;
    logic [NW-1:0]        cnt_inc;
    logic [NW-1:0]        need;
    logic                 div_start;
    logic                 div_done;
    logic signed [SW-1:0] div_q;
    logic                 in_window, below;
    logic                 up_end, down_end, timed_out;
    logic [PW-1:0]        seed_tap;
    gtsc_pkg::op_t        op;

    assign op        = gtsc_pkg::op_t'(cmd.op);
    assign cmd.ready = (state_reg == gtsc_pkg::SEQ_IDLE) && (!rvalid_reg || res.ready);
    assign accept    = cmd.valid && cmd.ready;

    // ---------------- configuration writes ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmin_reg <= '0;
            tmax_reg <= SW'(24'sh7FFFFF);
            spa_reg  <= NW'(16);
            tlim_reg <= TW'(1000);
            ftap_reg <= PW'(128);
            tinc_reg <= PW'(8);
        end
        else if (cfg_we)
        begin
            case (gtsc_pkg::cfg_reg_t'(cfg_index))
                gtsc_pkg::REG_TARGET_MIN: tmin_reg <= $signed(cfg_data[SW-1:0]);
                gtsc_pkg::REG_TARGET_MAX: tmax_reg <= $signed(cfg_data[SW-1:0]);
                gtsc_pkg::REG_SAMPLES:    spa_reg  <= cfg_data[NW-1:0];
                gtsc_pkg::REG_TIMEOUT:    tlim_reg <= cfg_data[TW-1:0];
                gtsc_pkg::REG_FIRST_TAP:  ftap_reg <= cfg_data[PW-1:0];
                gtsc_pkg::REG_TAP_INCR:   tinc_reg <= cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- datapath helpers ----------------
    assign sum_add   = sum_reg + AW'(cmd.adc_value);
    assign cnt_inc   = cnt_reg + 1'b1;
    assign need      = (spa_reg == '0) ? NW'(1) : spa_reg;
    assign seed_tap  = (ftap_reg > MAX_TAP_P) ? MAX_TAP_P : ftap_reg;

    // trial verdict on the selected average
    assign in_window = (avg_j >= tmin_reg) && (avg_j <= tmax_reg);
    assign below     = avg_j < tmin_reg;
    assign up_end    = ({1'b0, tap_reg} + {1'b0, tinc_reg}) >= MAX_TAP_X;
    assign down_end  = tap_reg <= tinc_reg;
    assign timed_out = ms_reg > tlim_reg;

    // serial divider: sum / count on the closing sample
    gtsc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_add),
        .divisor  (cnt_inc),
        .done     (div_done),
        .quotient (div_q)
    );

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        tap_next   = tap_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        ms_next    = ms_reg;
        avg_next   = avg_reg;
        wr         = 1'b0;
        dn         = 1'b0;
        judge_en   = 1'b0;
        avg_j      = '0;
        div_start  = 1'b0;
        load_res   = 1'b0;

        case (state_reg)
            gtsc_pkg::SEQ_IDLE:
            begin
                if (accept)
                begin
                    load_res = 1'b1;
                    case (op)
                        gtsc_pkg::OP_START:
                        begin
                            tap_next  = seed_tap;
                            ms_next   = '0;
                            sum_next  = '0;
                            cnt_next  = '0;
                            mode_next = gtsc_pkg::MODE_SEARCH;
                            wr        = 1'b1;
                        end
                        gtsc_pkg::OP_SAMPLE:
                        begin
                            if (mode_reg == gtsc_pkg::MODE_SEARCH)
                            begin
                                if (!cmd.sample_ok)
                                begin
                                    // failed read: judge at once with a zero average
                                    sum_next = '0;
                                    cnt_next = '0;
                                    dn       = 1'b1;
                                    judge_en = 1'b1;
                                end
                                else if (cnt_inc >= need)
                                begin
                                    sum_next   = '0;
                                    cnt_next   = '0;
                                    div_start  = 1'b1;
                                    load_res   = 1'b0;
                                    state_next = gtsc_pkg::SEQ_DIV;
                                end
                                else
                                begin
                                    sum_next = sum_add;
                                    cnt_next = cnt_inc;
                                end
                            end
                        end
                        gtsc_pkg::OP_TICK:
                        begin
                            if (ms_reg != '1)
                                ms_next = ms_reg + 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            gtsc_pkg::SEQ_DIV:
            begin
                if (div_done)
                begin
                    avg_j      = div_q;
                    dn         = 1'b1;
                    judge_en   = 1'b1;
                    load_res   = 1'b1;
                    state_next = gtsc_pkg::SEQ_IDLE;
                end
            end
            default: state_next = gtsc_pkg::SEQ_IDLE;
        endcase

        if (judge_en)
        begin
            avg_next = avg_j;
            if (in_window)
                mode_next = gtsc_pkg::MODE_DONE;
            else if (below ? up_end : down_end)
                mode_next = gtsc_pkg::MODE_FAIL;   // tap range exhausted
            else if (timed_out)
                mode_next = gtsc_pkg::MODE_FAIL;
            else
            begin
                tap_next = below ? tap_reg + tinc_reg : tap_reg - tinc_reg;
                wr       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= gtsc_pkg::SEQ_IDLE;
            mode_reg   <= gtsc_pkg::MODE_IDLE;
            tap_reg    <= '0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            ms_reg     <= '0;
            avg_reg    <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            tap_reg   <= tap_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            ms_reg    <= ms_next;
            avg_reg   <= avg_next;
            if (load_res)
                rvalid_reg <= 1'b1;
            else if (res.ready)
                rvalid_reg <= 1'b0;
        end
    end

    // result payload, loaded with the post-update state
    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            rmode_reg  <= mode_next;
            rtap_reg   <= tap_next;
            rwrite_reg <= wr;
            ravg_reg   <= avg_next;
            rdone_reg  <= dn;
        end
    end

    assign res.valid         = rvalid_reg;
    assign res.search_status = rmode_reg;
    assign res.tap_now       = rtap_reg;
    assign res.tap_write     = rwrite_reg;
    assign res.average_value = ravg_reg;
    assign res.average_done  = rdone_reg;

    // ---------------- assertions ----------------
    // divider only reports while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == gtsc_pkg::SEQ_DIV)
        else $error("divider done outside divide wait");

    // a pending division never overlaps a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gtsc_pkg::SEQ_DIV |-> !rvalid_reg)
        else $error("result register busy during division");

    // a start yields a searching result with a tap write
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == gtsc_pkg::OP_START |=>
            rvalid_reg && rwrite_reg && rmode_reg == gtsc_pkg::MODE_SEARCH)
        else $error("start did not request a tap write");

    // tap never leaves the legal range
    assert property (@(posedge clk) disable iff (!rst_n)
        tap_reg <= MAX_TAP_P)
        else $error("tap above maximum");

    // the closing sample enters the divide wait with no result pending
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> state_reg == gtsc_pkg::SEQ_DIV && !rvalid_reg)
        else $error("division start without divide wait");

endmodule

// ===== bench/gain_tap_search_calibrator_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gain_tap_search_calibrator_unit_test: tap search calibrator bench
// Drives start, ADC sample, tick and unused commands through the command
// channel and tracks the tap search in a scoreboard. Every result transaction
// is compared field by field with the predicted one. A directed opening covers
// field extremes and the corner cases of the search. It is followed by
// randomized phases, each with its own register settings and a simple plant
// whose reading follows the tap, so that most searches run several steps.
// ----------------------------------------------------------------------------
module gain_tap_search_calibrator_unit_test;
    import gtsc_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int MAX_TAP      = 255;
    localparam int RANDOM_ITEMS = 650;
    localparam int RUN_LIMIT_NS = 2_000_000;
    localparam int MAX_PRINTED  = 100;         // cap on mismatch lines

    // One result transaction as seen on the res channel
    typedef struct {
        logic [1:0]                  status;
        logic [TAP_W-1:0]            tap;
        logic                        wr;
        logic signed [SAMPLE_W-1:0]  avg;
        logic                        done;
    } tap_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the search state and the registers,
    // predicts one result per accepted command and queues it in order.
    // ------------------------------------------------------------------------
    class tap_search_tracker;
        // register copies
        logic signed [SAMPLE_W-1:0]  win_lo;
        logic signed [SAMPLE_W-1:0]  win_hi;
        logic [COUNT_W-1:0]          avg_len;
        logic [TIME_W-1:0]           time_limit;
        logic [TAP_W-1:0]            seed_tap;
        logic [TAP_W-1:0]            step_size;
        // search state
        mode_t                       mode;
        logic [TAP_W-1:0]            tap;
        longint                      acc;
        int                          taken;
        logic [TIME_W-1:0]           ms;
        logic signed [SAMPLE_W-1:0]  last_avg;

        tap_result_t                 pending_results[$];
        int                          mismatch_count;

        function new();
            win_lo         = '0;
            win_hi         = 24'sh7FFFFF;
            avg_len        = 16'd16;
            time_limit     = 32'd1000;
            seed_tap       = 8'd128;
            step_size      = 8'd8;
            mode           = MODE_IDLE;
            tap            = '0;
            acc            = 0;
            taken          = 0;
            ms             = '0;
            last_avg       = '0;
            mismatch_count = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_TARGET_MIN: win_lo     = d[SAMPLE_W-1:0];
                REG_TARGET_MAX: win_hi     = d[SAMPLE_W-1:0];
                REG_SAMPLES:    avg_len    = d[COUNT_W-1:0];
                REG_TIMEOUT:    time_limit = d[TIME_W-1:0];
                REG_FIRST_TAP:  seed_tap   = d[TAP_W-1:0];
                REG_TAP_INCR:   step_size  = d[TAP_W-1:0];
                default: ;
            endcase
        endfunction

        // Judge a finished average; returns 1 when a new tap is to be written.
        function bit judge(logic signed [SAMPLE_W-1:0] a);
            int step;
            int nxt;
            step     = int'(step_size);
            nxt      = int'(tap);
            last_avg = a;
            if (a >= win_lo && a <= win_hi)
            begin
                mode = MODE_DONE;
                return 1'b0;
            end
            if (a < win_lo)
            begin
                if (nxt >= MAX_TAP - step)
                begin
                    mode = MODE_FAIL;
                    return 1'b0;
                end
                nxt += step;
            end
            else
            begin
                if (nxt <= step)
                begin
                    mode = MODE_FAIL;
                    return 1'b0;
                end
                nxt -= step;
            end
            if (ms > time_limit)
            begin
                mode = MODE_FAIL;
                return 1'b0;
            end
            tap = nxt[TAP_W-1:0];
            return 1'b1;
        endfunction

        function void take_command(op_t op, logic signed [SAMPLE_W-1:0] v, logic ok);
            tap_result_t                 r;
            int                          need;
            longint                      q;
            logic signed [SAMPLE_W-1:0]  a;
            r.wr   = 1'b0;
            r.done = 1'b0;
            a      = '0;
            case (op)
                OP_START:
                begin
                    tap   = (int'(seed_tap) > MAX_TAP) ? TAP_W'(MAX_TAP) : seed_tap;
                    ms    = '0;
                    acc   = 0;
                    taken = 0;
                    mode  = MODE_SEARCH;
                    r.wr  = 1'b1;
                end
                OP_SAMPLE:
                begin
                    if (mode == MODE_SEARCH)
                    begin
                        need = (avg_len == 0) ? 1 : int'(avg_len);
                        if (!ok)
                            r.done = 1'b1;       // failed read judges a zero average
                        else
                        begin
                            acc += v;
                            taken++;
                            if (taken >= need)
                            begin
                                q      = acc / longint'(taken);   // truncates toward zero
                                a      = q[SAMPLE_W-1:0];
                                r.done = 1'b1;
                            end
                        end
                        if (r.done)
                        begin
                            acc   = 0;
                            taken = 0;
                            r.wr  = judge(a);
                        end
                    end
                end
                OP_TICK:
                begin
                    if (ms != '1)
                        ms++;
                end
                default: ;
            endcase
            r.status = mode;
            r.tap    = tap;
            r.avg    = last_avg;
            pending_results.push_back(r);
        endfunction

        task flag_mismatch(string msg);
            mismatch_count++;
            if (mismatch_count <= MAX_PRINTED)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        task match_result(tap_result_t got);
            tap_result_t want;
            if (pending_results.size() == 0)
            begin
                flag_mismatch("result transaction with no command outstanding");
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.tap !== want.tap || got.wr !== want.wr ||
                got.avg !== want.avg || got.done !== want.done)
                flag_mismatch($sformatf(
                    "status %0d/%0d tap %0d/%0d write %b/%b avg %0d/%0d done %b/%b (got/exp)",
                    got.status, want.status, got.tap, want.tap, got.wr, want.wr,
                    got.avg, want.avg, got.done, want.done));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    bit                     steady = 1'b0;   // both sides drop their random idling

    // plant used by the random phases: reading = center + slope * (tap - goal_tap)
    int                     goal_tap;
    int                     slope;
    int                     center;
    int                     noise;

    tap_search_tracker      sb = new();

    gtsc_cmd_if cmd_if();
    gtsc_res_if res_if();

    gain_tap_search_calibrator_unit #(.MAX_TAP(MAX_TAP)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_if),
        .res       (res_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Result side stalls about one cycle in ten, except in the steady stretch.
    always @(posedge clk)
        res_if.ready <= steady || ($urandom_range(99) >= 10);

    // Outputs are sampled at the falling edge: a transaction seen here is the
    // one taken at the next rising edge, since ready only moves on that edge.
    always @(negedge clk)
    begin : watch_results
        tap_result_t got;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got.status = res_if.search_status;
            got.tap    = res_if.tap_now;
            got.wr     = res_if.tap_write;
            got.avg    = res_if.average_value;
            got.done   = res_if.average_done;
            sb.match_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // One command transaction. Entered and left at a rising edge. Valid is not
    // lowered on the way out, so back-to-back commands keep it high; anything
    // else that lets time pass lowers it first.
    task automatic send_cmd(op_t op, logic signed [SAMPLE_W-1:0] v, logic ok);
        while (!steady && $urandom_range(99) < 10)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.op           <= op;
        cmd_if.adc_value    <= v;
        cmd_if.sample_ok    <= ok;
        do
            @(negedge clk);
        while (!cmd_if.ready);
        @(posedge clk);                  // the transaction is taken here
        sb.take_command(op, v, ok);
    endtask

    // Sender pause: hold off until every predicted result has come back.
    // A result still held back by the averaging divider is already covered
    // by the queue.
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        sb.set_reg(idx, d);
        @(posedge clk);
    endtask

    // Registers only change with the block idle.
    task automatic reconfigure(logic signed [SAMPLE_W-1:0] lo, logic signed [SAMPLE_W-1:0] hi,
                               logic [COUNT_W-1:0] n, logic [TIME_W-1:0] lim,
                               logic [TAP_W-1:0] first, logic [TAP_W-1:0] incr);
        drain_results();
        write_reg(REG_TARGET_MIN, CFG_DATA_W'(lo));
        write_reg(REG_TARGET_MAX, CFG_DATA_W'(hi));
        write_reg(REG_SAMPLES,    CFG_DATA_W'(n));
        write_reg(REG_TIMEOUT,    lim);
        write_reg(REG_FIRST_TAP,  CFG_DATA_W'(first));
        write_reg(REG_TAP_INCR,   CFG_DATA_W'(incr));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] plant_reading();
        longint v;
        v = longint'(center) + longint'(slope) * (int'(sb.tap) - goal_tap)
            + (int'($urandom_range(2 * noise)) - noise);
        if (v > 8388607)
            v = 8388607;
        if (v < -8388608)
            v = -8388608;
        return v[SAMPLE_W-1:0];
    endfunction

    // Directed opening, first at the reset register values.
    task automatic directed_checks();
        send_cmd(OP_SAMPLE, 24'sh7FFFFF, 1'b1);    // idle: sample ignored
        send_cmd(OP_NONE,   24'sh800000, 1'b0);    // unused op
        send_cmd(OP_TICK,   24'sh000000, 1'b1);
        send_cmd(OP_START,  24'sh000000, 1'b0);    // tap 128, write
        send_cmd(OP_SAMPLE, 24'sh800000, 1'b1);    // most negative reading
        send_cmd(OP_SAMPLE, 24'sh123456, 1'b0);    // failed read: zero lands in window
        send_cmd(OP_SAMPLE, 24'sh000001, 1'b1);    // calibrated: ignored

        // zero sample count acts as one; top tap with a full step fails going down
        reconfigure(24'sd1000, 24'sd2000, 16'd0, 32'd2, 8'd255, 8'd255);
        send_cmd(OP_START,  24'sh7FFFFF, 1'b1);
        send_cmd(OP_SAMPLE, 24'sh7FFFFF, 1'b1);

        // step up from tap 0, then time out; restart from fail and mid-search
        reconfigure(24'sd1000, 24'sd2000, 16'd1, 32'd1, 8'd0, 8'd10);
        send_cmd(OP_START,  24'sh000000, 1'b1);
        send_cmd(OP_SAMPLE, 24'sh800000, 1'b1);
        send_cmd(OP_TICK,   24'sh7FFFFF, 1'b0);
        send_cmd(OP_TICK,   24'sh000000, 1'b1);
        send_cmd(OP_SAMPLE, -24'sd5,     1'b1);    // elapsed past the limit: fail
        send_cmd(OP_START,  24'sh000000, 1'b0);
        send_cmd(OP_START,  24'sh000000, 1'b1);
        send_cmd(OP_SAMPLE, 24'sd1500,   1'b1);    // inside the window

        // step up past the top end; -1 / 2 must truncate to zero
        reconfigure(24'sh7FFFFF, 24'sh7FFFFF, 16'd2, 32'hFFFF_FFFF, 8'd250, 8'd5);
        send_cmd(OP_START,  24'sh000000, 1'b0);
        send_cmd(OP_SAMPLE, 24'sh000000, 1'b1);
        send_cmd(OP_SAMPLE, -24'sd1,     1'b1);

        // longest average, zero step and zero timeout
        reconfigure(24'sh800000, 24'sh800000, 16'hFFFF, 32'd0, 8'd100, 8'd0);
        send_cmd(OP_START,  24'sh000000, 1'b0);
        send_cmd(OP_SAMPLE, 24'sh7FFFFF, 1'b1);
        send_cmd(OP_SAMPLE, 24'sh800000, 1'b1);
        send_cmd(OP_SAMPLE, 24'sh000000, 1'b0);    // zero is above the window: tap stays
        send_cmd(OP_TICK,   24'sh000000, 1'b0);
        send_cmd(OP_SAMPLE, 24'sh000000, 1'b0);    // elapsed 1 > 0: fail
    endtask

    // Random register set and plant for one phase; some phases go to extremes.
    task automatic random_setup();
        int                          step;
        int                          half;
        int                          kind;
        int                          r;
        logic signed [SAMPLE_W-1:0]  lo;
        logic signed [SAMPLE_W-1:0]  hi;
        logic [COUNT_W-1:0]          n;
        logic [TIME_W-1:0]           lim;
        logic [TAP_W-1:0]            first;
        logic [TAP_W-1:0]            incr;

        slope    = $urandom_range(1, 20000);
        step     = $urandom_range(1, 12);
        noise    = $urandom_range(slope / 4);
        goal_tap = $urandom_range(255);
        center   = int'($urandom_range(8000000)) - 4000000;
        // wide enough that a tap within half a step of the goal usually lands
        half     = slope * step / 2 + slope / 4 + int'($urandom_range(slope));
        lo       = SAMPLE_W'(center - half);
        hi       = SAMPLE_W'(center + half);
        incr     = TAP_W'(step);
        first    = TAP_W'($urandom_range(255));

        r = $urandom_range(19);
        if (r == 0)
            n = '0;
        else if (r == 1)
            n = COUNT_W'($urandom_range(100, 400));
        else
            n = COUNT_W'($urandom_range(1, 6));

        if ($urandom_range(3) == 0)
            lim = $urandom_range(30);
        else
            lim = $urandom_range(1000, 32'hFFFF_FFFF);

        kind = $urandom_range(7);
        case (kind)
            0:
            begin
                lo = 24'sh800000;
                hi = 24'sh7FFFFF;
            end
            1:
            begin
                lo = SAMPLE_W'($urandom());          // may come out inverted
                hi = SAMPLE_W'($urandom());
            end
            2:
            begin
                incr  = $urandom_range(1) ? 8'd0 : 8'd255;
                first = $urandom_range(1) ? 8'd0 : 8'd255;
            end
            3:
                lim = $urandom_range(1) ? 32'd0 : 32'hFFFF_FFFF;
            default: ;
        endcase
        reconfigure(lo, hi, n, lim, first, incr);
    endtask

    // Mostly plant-driven searches; ignored commands do not count toward quota.
    task automatic run_phase(int quota);
        int                          counted;
        int                          r;
        op_t                         op;
        logic signed [SAMPLE_W-1:0]  v;
        logic                        ok;

        send_cmd(OP_START, SAMPLE_W'($urandom()), 1'($urandom_range(1)));
        counted = 1;
        while (counted < quota)
        begin
            r  = $urandom_range(99);
            v  = SAMPLE_W'($urandom());
            ok = 1'($urandom_range(1));
            if (sb.mode != MODE_SEARCH && $urandom_range(9) < 7)
                op = OP_START;
            else if (r < 4)
                op = OP_NONE;
            else if (r < 8)
                op = OP_START;
            else if (r < 22)
                op = OP_TICK;
            else
            begin
                op = OP_SAMPLE;
                ok = ($urandom_range(99) >= 4);
                if ($urandom_range(99) >= 8)
                    v = plant_reading();
            end
            if (!(op == OP_NONE || (op == OP_SAMPLE && sb.mode != MODE_SEARCH)))
                counted++;
            send_cmd(op, v, ok);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int total;
        int phase_no;
        int quota;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_TARGET_MIN;
        cfg_data            = '0;
        cmd_if.valid        = 1'b0;
        cmd_if.op           = OP_START;
        cmd_if.adc_value    = '0;
        cmd_if.sample_ok    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_checks();

        total    = 0;
        phase_no = 0;
        while (total < RANDOM_ITEMS)
        begin
            random_setup();
            steady = (phase_no >= 4 && phase_no < 8);   // long stretch with no idling
            quota  = $urandom_range(20, 60);
            run_phase(quota);
            total += quota;
            phase_no++;
        end

        drain_results();
        repeat (50) @(posedge clk);   // anything extra would show up as unexpected
        if (sb.mismatch_count == 0 && sb.pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
